// ===== rtl/tsp_pkg.sv =====
// Shared types, constants and the pitch-to-prescaler function of the tone sequence player.
package tsp_pkg;

    localparam int unsigned PITCH_W = 18;
    localparam int unsigned INDEX_W = 6;
    localparam int unsigned LEN_W   = 8;
    localparam int unsigned DIV_W   = 8;
    localparam int unsigned SEL_W   = 3;
    localparam int unsigned QDEPTH  = 2;

    // Input command codes as they arrive on the stream.
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;
    localparam logic [1:0] CMD_TICK  = 2'd3;

    // Note kinds; any code with the upper bit set ends the sequence.
    localparam logic [1:0] KIND_TONE  = 2'd0;
    localparam logic [1:0] KIND_PAUSE = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    localparam logic [SEL_W-1:0] SEL_FIRST = 3'b010;
    localparam logic [SEL_W-1:0] SEL_LAST  = 3'b111;
    localparam logic [SEL_W-1:0] SEL_OFF   = 3'b000;
    localparam logic [DIV_W-1:0] DIV_MAX   = 8'd255;

    // Configuration register byte addresses.
    localparam logic [2:0] ADDR_PLAY_MODE = 3'd0;
    localparam logic [2:0] ADDR_REPEAT    = 3'd4;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2,
        OP_TICK  = 2'd3
    } t_op;

    typedef struct packed {
        logic [LEN_W-1:0]   length;
        logic [1:0]         kind;
        logic [PITCH_W-1:0] pitch;
    } t_note;

    typedef struct packed {
        t_op               op;
        logic              index_ok;
        logic [INDEX_W-1:0] index;
        t_note             note;
    } t_item;

    typedef struct packed {
        logic [DIV_W-1:0] divider;
        logic [SEL_W-1:0] select;
    } t_tone;

    typedef struct packed {
        logic             tone_on;
        logic [DIV_W-1:0] divider_value;
        logic [SEL_W-1:0] clock_select;
        logic             playing;
        logic             finished;
    } t_result;

    function automatic logic kind_is_end(input logic [1:0] kind);
        return kind[1];
    endfunction

    // First shift of {3,5,6,7,8,10} whose quotient minus one fits in 8 bits.
    function automatic t_tone pitch_to_tone(input logic [PITCH_W-1:0] pitch);
        t_tone       t;
        logic [14:0] v3;
        logic [12:0] v5;
        logic [11:0] v6;
        logic [10:0] v7;
        logic [9:0]  v8;
        logic [7:0]  v10;
        v3  = pitch[17:3];
        v5  = pitch[17:5];
        v6  = pitch[17:6];
        v7  = pitch[17:7];
        v8  = pitch[17:8];
        v10 = pitch[17:10];
        priority if (v3 == 15'd0) begin
            t = '{divider: '0, select: SEL_FIRST};
        end else if (v3 <= 15'd256) begin
            t = '{divider: DIV_W'(v3 - 15'd1), select: SEL_FIRST};
        end else if (v5 <= 13'd256) begin
            t = '{divider: DIV_W'(v5 - 13'd1), select: SEL_FIRST + 3'd1};
        end else if (v6 <= 12'd256) begin
            t = '{divider: DIV_W'(v6 - 12'd1), select: SEL_FIRST + 3'd2};
        end else if (v7 <= 11'd256) begin
            t = '{divider: DIV_W'(v7 - 11'd1), select: SEL_FIRST + 3'd3};
        end else if (v8 <= 10'd256) begin
            t = '{divider: DIV_W'(v8 - 10'd1), select: SEL_FIRST + 3'd4};
        end else if (v10 != 8'd0) begin
            t = '{divider: v10 - 8'd1, select: SEL_LAST};
        end else begin
            t = '{divider: DIV_MAX, select: SEL_LAST};
        end
        return t;
    endfunction

endpackage

// ===== rtl/tsp_front.sv =====
// Front end: accepts stream transactions and classifies them into queue items.
module tsp_front #(
    parameter int unsigned NOTE_DEPTH = 64
) (
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_cmd,
    input  logic [39:0]          i_data,
    input  logic                 i_queue_full,
    output logic                 o_push,
    output tsp_pkg::t_item       o_item
);
    import tsp_pkg::*;

    localparam logic [15:0] DEPTH_LIMIT = 16'(NOTE_DEPTH);

    t_op op;

    always_comb begin
        unique case (i_cmd)
            CMD_WRITE: op = OP_WRITE;
            CMD_START: op = OP_START;
            CMD_STOP:  op = OP_STOP;
            CMD_TICK:  op = OP_TICK;
            default:   op = OP_TICK;
        endcase
    end

    always_comb begin
        o_item.op          = op;
        o_item.index       = i_data[5:0];
        o_item.note.pitch  = i_data[23:6];
        o_item.note.kind   = i_data[25:24];
        o_item.note.length = i_data[33:26];
        // Writes beyond the table are dropped by the back end.
        o_item.index_ok    = 16'(i_data[5:0]) < DEPTH_LIMIT;
    end

    assign o_ready = !i_queue_full;
    assign o_push  = i_valid && !i_queue_full;

endmodule

// ===== rtl/tsp_queue.sv =====
// Two-entry queue that decouples the front end from the back end.
module tsp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tsp_pkg::t_item i_item,
    output logic           o_full,
    output logic           o_valid,
    output tsp_pkg::t_item o_item,
    input  logic           i_pop
);
    import tsp_pkg::*;

    localparam int unsigned PTR_W = $clog2(QDEPTH);

    t_item              r_slot [QDEPTH];
    logic [PTR_W-1:0]   r_wptr, n_wptr;
    logic [PTR_W-1:0]   r_rptr, n_rptr;
    logic [PTR_W:0]     r_count, n_count;
    logic               do_push, do_pop;

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_full  = r_count == (PTR_W+1)'(QDEPTH);
    assign o_valid = r_count != '0;
    assign o_item  = r_slot[r_rptr];

    always_comb begin
        n_wptr  = do_push ? r_wptr + PTR_W'(1) : r_wptr;
        n_rptr  = do_pop ? r_rptr + PTR_W'(1) : r_rptr;
        n_count = r_count + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wptr] <= i_item;
        end
    end

endmodule

// ===== rtl/tsp_back.sv =====
// Back end: note table, playback state machine and the registered result stage.
module tsp_back #(
    parameter int unsigned NOTE_DEPTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [7:0]       i_play_mode,
    input  logic             i_repeat,
    input  logic             i_valid,
    input  tsp_pkg::t_item   i_item,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output tsp_pkg::t_result o_result
);
    import tsp_pkg::*;

    localparam int unsigned IDX_W = $clog2(NOTE_DEPTH);
    localparam logic [IDX_W:0] LAST_CUR = (IDX_W+1)'(NOTE_DEPTH - 2);

    typedef enum logic [1:0] {
        ST_RUN   = 2'b01,
        ST_FETCH = 2'b10
    } t_state;

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_cur, n_cur;
    logic [LEN_W-1:0]   r_tick, n_tick;
    logic [LEN_W-1:0]   r_len, n_len;
    logic               r_active, n_active;
    logic               r_tone, n_tone;
    logic [DIV_W-1:0]   r_div, n_div;
    logic [SEL_W-1:0]   r_sel, n_sel;
    t_note              r_head, n_head;
    logic               r_last, n_last;
    logic               r_out_valid;
    t_result            r_out;

    t_note              r_mem [NOTE_DEPTH];
    t_note              r_rd;
    logic               mem_we, rd_en;
    logic [IDX_W-1:0]   waddr, raddr;
    logic [15:0]        wide_index;

    logic               out_free, load_out, fin;
    logic [LEN_W-1:0]   tick_next;
    logic               cut;
    logic               head_end;
    t_note              load_src;
    logic               do_load;
    t_tone              tone_val;

    assign out_free   = !r_out_valid || i_out_ready;
    assign wide_index = 16'(i_item.index);
    assign waddr      = wide_index[IDX_W-1:0];
    assign raddr      = r_cur + IDX_W'(1);
    assign tick_next  = r_tick + LEN_W'(1);
    assign head_end   = kind_is_end(r_head.kind);
    assign cut        = (i_play_mode == 8'd0) ? (tick_next == r_len)
                                              : (tick_next == i_play_mode);
    assign tone_val   = pitch_to_tone(load_src.pitch);

    always_comb begin
        n_state  = r_state;
        n_cur    = r_cur;
        n_tick   = r_tick;
        n_len    = r_len;
        n_active = r_active;
        n_tone   = r_tone;
        n_div    = r_div;
        n_sel    = r_sel;
        n_head   = r_head;
        n_last   = r_last;
        o_pop    = 1'b0;
        load_out = 1'b0;
        fin      = 1'b0;
        mem_we   = 1'b0;
        rd_en    = 1'b0;
        do_load  = 1'b0;
        load_src = r_head;

        unique case (r_state)
            ST_RUN: begin
                if (i_valid && out_free) begin
                    unique case (i_item.op)
                        OP_WRITE: begin
                            o_pop    = 1'b1;
                            load_out = 1'b1;
                            if (i_item.index_ok) begin
                                mem_we = 1'b1;
                                if (i_item.index == '0) begin
                                    n_head = i_item.note;
                                end
                            end
                        end
                        OP_START, OP_STOP: begin
                            o_pop    = 1'b1;
                            load_out = 1'b1;
                            n_active = 1'b0;
                            n_tone   = 1'b0;
                            n_sel    = SEL_OFF;
                            if (i_item.op == OP_START && !head_end) begin
                                n_cur    = '0;
                                n_active = 1'b1;
                                do_load  = 1'b1;
                            end
                        end
                        OP_TICK: begin
                            if (!r_active) begin
                                o_pop    = 1'b1;
                                load_out = 1'b1;
                            end else if (cut) begin
                                o_pop    = 1'b1;
                                load_out = 1'b1;
                                n_tick   = tick_next;
                                n_tone   = 1'b0;
                                n_sel    = SEL_OFF;
                            end else if (tick_next > r_len) begin
                                // The next entry is read from the table into a register and used in the fetch state.
                                n_tick  = tick_next;
                                rd_en   = 1'b1;
                                n_last  = {1'b0, r_cur} >= LAST_CUR;
                                n_state = ST_FETCH;
                            end else begin
                                o_pop    = 1'b1;
                                load_out = 1'b1;
                                n_tick   = tick_next;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_FETCH: begin
                if (out_free) begin
                    o_pop    = 1'b1;
                    load_out = 1'b1;
                    n_state  = ST_RUN;
                    if (!r_last && !kind_is_end(r_rd.kind)) begin
                        n_cur    = raddr;
                        load_src = r_rd;
                        do_load  = 1'b1;
                    end else if (i_repeat && !head_end) begin
                        n_cur   = '0;
                        do_load = 1'b1;
                    end else begin
                        n_active = 1'b0;
                        n_tone   = 1'b0;
                        n_sel    = SEL_OFF;
                        fin      = 1'b1;
                    end
                end
            end
            default: n_state = ST_RUN;
        endcase

        if (do_load) begin
            n_len  = load_src.length;
            n_tick = '0;
            if (load_src.kind == KIND_PAUSE) begin
                n_tone = 1'b0;
                n_sel  = SEL_OFF;
            end else begin
                n_tone = 1'b1;
                n_div  = tone_val.divider;
                n_sel  = tone_val.select;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_cur       <= '0;
            r_tick      <= '0;
            r_len       <= '0;
            r_active    <= 1'b0;
            r_tone      <= 1'b0;
            r_div       <= '0;
            r_sel       <= SEL_OFF;
            r_head      <= '0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cur    <= n_cur;
            r_tick   <= n_tick;
            r_len    <= n_len;
            r_active <= n_active;
            r_tone   <= n_tone;
            r_div    <= n_div;
            r_sel    <= n_sel;
            r_head   <= n_head;
            r_last   <= n_last;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= '{tone_on:       n_tone,
                       divider_value: n_div,
                       clock_select:  n_tone ? n_sel : SEL_OFF,
                       playing:       n_active,
                       finished:      fin};
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[waddr] <= i_item.note;
        end
        if (rd_en) begin
            r_rd <= r_mem[raddr];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule

// ===== rtl/tone_sequence_player.sv =====
// Tone sequence player: takes one transaction per cycle from a two-entry queue while the
// output is free and no fetch is pending; writes, start, stop and ticks that stay on a note
// are handled in the run state, while a tick that runs past the end of its note goes through
// a fetch state, because the next entry comes from a memory with a registered read port. Entry
// 0 is also kept in a shadow register so start and repeat need no table read. Results leave
// through an output register that takes a new result in the cycle the previous one is taken.
module tone_sequence_player #(
    parameter int unsigned NOTE_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // note_index[5:0], note_pitch[23:6], note_kind[25:24], note_length[33:26], zeros above
    input  logic [39:0] i_s_axis_tdata,
    // cmd[1:0]
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // tone_on[0], divider_value[8:1], clock_select[11:9], playing[12], zeros above
    output logic [15:0] o_m_axis_tdata,
    // finished
    output logic        o_m_axis_tlast,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);
    import tsp_pkg::*;

    logic [7:0] r_play_mode;
    logic       r_repeat;
    logic       cfg_write;
    logic       push, queue_full, queue_valid, pop;
    t_item      push_item, queue_item;
    t_result    result;

    assign o_pready  = 1'b1;
    assign cfg_write = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_play_mode <= '0;
            r_repeat    <= 1'b0;
        end else if (cfg_write) begin
            if (i_paddr == ADDR_PLAY_MODE) begin
                r_play_mode <= i_pwdata[7:0];
            end
            if (i_paddr == ADDR_REPEAT) begin
                r_repeat <= i_pwdata[0];
            end
        end
    end

    always_comb begin
        priority if (i_paddr == ADDR_PLAY_MODE) begin
            o_prdata = {24'd0, r_play_mode};
        end else if (i_paddr == ADDR_REPEAT) begin
            o_prdata = {31'd0, r_repeat};
        end else begin
            o_prdata = '0;
        end
    end

    tsp_front #(.NOTE_DEPTH(NOTE_DEPTH)) u_front (
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_cmd        (i_s_axis_tuser),
        .i_data       (i_s_axis_tdata),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_item       (push_item)
    );

    tsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .o_item  (queue_item),
        .i_pop   (pop)
    );

    tsp_back #(.NOTE_DEPTH(NOTE_DEPTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_play_mode (r_play_mode),
        .i_repeat    (r_repeat),
        .i_valid     (queue_valid),
        .i_item      (queue_item),
        .o_pop       (pop),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_result    (result)
    );

    assign o_m_axis_tdata = {3'd0, result.playing, result.clock_select,
                             result.divider_value, result.tone_on};
    assign o_m_axis_tlast = result.finished;

endmodule

// ===== rtl/tsp_checker.sv =====
// Port-level checker for the tone sequence player, bound to the top level.
module tsp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] i_m_tdata,
    input logic        i_m_tlast
);

    // The prescaler only runs while a tone sounds, with a code from two to seven.
    a_select_follows_tone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |->
            (i_m_tdata[0] ? (i_m_tdata[11:9] >= 3'd2)
                          : (i_m_tdata[11:9] == 3'd0)))
        else $error("clock select does not match tone state");

    // A tone can only sound while the sequence plays.
    a_tone_needs_play: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tdata[0] |-> i_m_tdata[12])
        else $error("tone on while stopped");

    // The transaction that ends playback reports the block silent and stopped.
    a_finish_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tlast |-> !i_m_tdata[12] && !i_m_tdata[0])
        else $error("finished while still playing");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=>
            i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tlast))
        else $error("result changed while stalled");

endmodule

bind tone_sequence_player tsp_checker u_tsp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata),
    .i_m_tlast  (o_m_axis_tlast)
);

// ===== bench/tone_sequence_player_checker.sv =====
// Checker for the tone sequence player: predicts each result from the accepted transactions.
module tone_sequence_player_checker #(
    parameter int unsigned NOTE_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [39:0] i_s_tdata,
    input  logic [1:0]  i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,
    input  logic        i_m_tlast,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_results_checked,
    output int          o_playbacks_ended
);
    timeunit 1ns;
    timeprecision 1ps;
    import tsp_pkg::*;

    // Shadow copy of the player state.
    t_note              note_mem [NOTE_DEPTH];
    int unsigned        cur_index;
    logic [LEN_W-1:0]   tick_cnt;
    logic [LEN_W-1:0]   cur_len;
    logic               active;
    logic               tone_en;
    logic [DIV_W-1:0]   div_q;
    logic [SEL_W-1:0]   sel_q;
    logic [7:0]         play_mode;
    logic               repeat_on;

    t_result            expected_outputs [$];
    t_result            want;
    t_result            seen;
    t_result            predicted;
    t_note              in_note;
    int                 fail_count;
    int                 results_checked;
    int                 playbacks_ended;

    task automatic report_mismatch(input string field, input int unsigned want_v,
                                   input int unsigned got_v);
        $display("[%0t] %s: expected %0d, got %0d", $realtime, field, want_v, got_v);
        fail_count++;
    endtask

    function automatic int shift_at(input int pos);
        case (pos)
            0:       return 3;
            1:       return 5;
            2:       return 6;
            3:       return 7;
            4:       return 8;
            default: return 10;
        endcase
    endfunction

    function automatic logic is_end_entry(input int unsigned idx);
        if (idx >= NOTE_DEPTH - 1) begin
            return 1'b1;
        end
        return note_mem[idx].kind >= KIND_END;
    endfunction

    task automatic silence();
        tone_en = 1'b0;
        sel_q   = SEL_OFF;
    endtask

    // Pick the first prescaler whose quotient minus one fits the 8-bit divider.
    task automatic tune(input logic [PITCH_W-1:0] pitch);
        logic [PITCH_W-1:0] q;
        int                 pos;
        bit                 found;
        found = 1'b0;
        div_q = DIV_MAX;
        sel_q = SEL_LAST;
        if (pitch < 8) begin
            div_q = '0;
            sel_q = SEL_FIRST;
        end else begin
            for (pos = 0; pos < 6 && !found; pos++) begin
                q = pitch >> shift_at(pos);
                if (q >= 1 && q <= 256) begin
                    div_q = DIV_W'(q - 1);
                    sel_q = SEL_FIRST + SEL_W'(pos);
                    found = 1'b1;
                end
            end
        end
        tone_en = 1'b1;
    endtask

    task automatic load_entry(input int unsigned idx);
        t_note n;
        n = note_mem[idx];
        if (n.kind == KIND_PAUSE) begin
            silence();
        end else begin
            tune(n.pitch);
        end
        cur_len  = n.length;
        tick_cnt = '0;
    endtask

    task automatic apply_transaction(input t_op op, input logic [INDEX_W-1:0] idx,
                                     input t_note nt, output t_result r);
        logic        fin;
        logic        at_end;
        int unsigned nxt;
        fin = 1'b0;
        case (op)
            OP_WRITE: begin
                if (idx < NOTE_DEPTH) begin
                    note_mem[idx] = nt;
                end
            end
            OP_START, OP_STOP: begin
                active = 1'b0;
                silence();
                if (op == OP_START && !is_end_entry(0)) begin
                    cur_index = 0;
                    active    = 1'b1;
                    load_entry(0);
                end
            end
            OP_TICK: begin
                if (active) begin
                    tick_cnt = tick_cnt + 8'd1;
                    if ((play_mode == 0 && tick_cnt == cur_len) ||
                        (play_mode != 0 && tick_cnt == play_mode)) begin
                        silence();
                    end else if (tick_cnt > cur_len) begin
                        nxt    = cur_index + 1;
                        at_end = is_end_entry(nxt);
                        if (at_end && repeat_on) begin
                            nxt    = 0;
                            at_end = is_end_entry(0);
                        end
                        if (at_end) begin
                            active = 1'b0;
                            silence();
                            fin = 1'b1;
                        end else begin
                            cur_index = nxt;
                            load_entry(nxt);
                        end
                    end
                end
            end
            default: ;
        endcase
        r.tone_on       = tone_en;
        r.divider_value = div_q;
        r.clock_select  = tone_en ? sel_q : SEL_OFF;
        r.playing       = active;
        r.finished      = fin;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cur_index = 0;
            tick_cnt  = '0;
            cur_len   = '0;
            active    = 1'b0;
            tone_en   = 1'b0;
            div_q     = '0;
            sel_q     = SEL_OFF;
            play_mode = '0;
            repeat_on = 1'b0;
            expected_outputs.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                seen.tone_on       = i_m_tdata[0];
                seen.divider_value = i_m_tdata[8:1];
                seen.clock_select  = i_m_tdata[11:9];
                seen.playing       = i_m_tdata[12];
                seen.finished      = i_m_tlast;
                if (expected_outputs.size() == 0) begin
                    report_mismatch("result with no transaction waiting", 0, 1);
                end else begin
                    want = expected_outputs.pop_front();
                    if (seen.tone_on != want.tone_on)
                        report_mismatch("tone_on", want.tone_on, seen.tone_on);
                    if (seen.divider_value != want.divider_value)
                        report_mismatch("divider_value", want.divider_value,
                                        seen.divider_value);
                    if (seen.clock_select != want.clock_select)
                        report_mismatch("clock_select", want.clock_select,
                                        seen.clock_select);
                    if (seen.playing != want.playing)
                        report_mismatch("playing", want.playing, seen.playing);
                    if (seen.finished != want.finished)
                        report_mismatch("finished", want.finished, seen.finished);
                    results_checked++;
                    if (want.finished) begin
                        playbacks_ended++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                in_note.pitch  = i_s_tdata[23:6];
                in_note.kind   = i_s_tdata[25:24];
                in_note.length = i_s_tdata[33:26];
                apply_transaction(t_op'(i_s_tuser), i_s_tdata[5:0], in_note, predicted);
                expected_outputs.push_back(predicted);
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr)
                    ADDR_PLAY_MODE: play_mode = i_pwdata[7:0];
                    ADDR_REPEAT:    repeat_on = i_pwdata[0];
                    default: ;
                endcase
            end
        end
        o_pending         <= expected_outputs.size();
        o_fail_count      <= fail_count;
        o_results_checked <= results_checked;
        o_playbacks_ended <= playbacks_ended;
    end

    final begin
        if (expected_outputs.size() != 0) begin
            $display("%0d results never arrived", expected_outputs.size());
        end
    end

endmodule

// ===== bench/tone_sequence_player_tb.sv =====
// Top of the tone sequence player testbench: clock, reset, stimulus and verdict.
module tone_sequence_player_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tsp_pkg::*;

    localparam int unsigned NOTE_DEPTH  = 64;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          SEGMENT_ITEMS = 10;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int results_checked;
    int playbacks_ended;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int holds_served  = 0;
    int sent_count    = 0;
    int ignored_count = 0;
    int settings_count = 0;
    int cycle_count   = 0;

    tone_sequence_player #(.NOTE_DEPTH(NOTE_DEPTH)) DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .o_prdata        (prdata),
        .o_pready        (pready)
    );

    tone_sequence_player_checker #(.NOTE_DEPTH(NOTE_DEPTH)) player_check (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_s_tvalid        (s_tvalid),
        .i_s_tready        (s_tready),
        .i_s_tdata         (s_tdata),
        .i_s_tuser         (s_tuser),
        .i_m_tvalid        (m_tvalid),
        .i_m_tready        (m_tready),
        .i_m_tdata         (m_tdata),
        .i_m_tlast         (m_tlast),
        .i_psel            (psel),
        .i_penable         (penable),
        .i_pwrite          (pwrite),
        .i_paddr           (paddr),
        .i_pwdata          (pwdata),
        .i_pready          (pready),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_results_checked (results_checked),
        .o_playbacks_ended (playbacks_ended)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    // Result side: random back-pressure, plus a long hold-off whenever one is requested.
    initial begin
        forever begin
            @(posedge clk);
            if (holds_served != hold_requests) begin
                holds_served++;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles", cycle_count);
        $display("Mismatches found");
        $finish;
    end

    function automatic t_note make_note(input logic [PITCH_W-1:0] pitch,
                                        input logic [1:0] kind,
                                        input logic [LEN_W-1:0] len);
        t_note n;
        n.pitch  = pitch;
        n.kind   = kind;
        n.length = len;
        return n;
    endfunction

    // Mostly short notes; the pitch width is random so every prescaler code shows up.
    function automatic t_note random_note(input logic [1:0] kind);
        int                 w;
        logic [PITCH_W-1:0] pitch;
        logic [LEN_W-1:0]   len;
        w     = $urandom_range(0, PITCH_W);
        pitch = PITCH_W'($urandom) & PITCH_W'((32'd1 << w) - 1);
        len   = ($urandom_range(15) == 0) ? LEN_W'($urandom_range(0, 255))
                                          : LEN_W'($urandom_range(0, 3));
        return make_note(pitch, kind, len);
    endfunction

    // Called at a rising edge; returns at the edge where the transaction was taken.
    task automatic send_item(input t_op op, input logic [INDEX_W-1:0] idx, input t_note nt);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'b0, nt.length, nt.kind, nt.pitch, idx};
        do @(posedge clk); while (!s_tready);
        sent_count++;
    endtask

    task automatic send_cmd(input t_op op);
        send_item(op, INDEX_W'($urandom), random_note(2'($urandom)));
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [7:0] mode, input logic rpt);
        wait_idle();
        write_reg(ADDR_PLAY_MODE, {24'b0, mode});
        write_reg(ADDR_REPEAT, {31'b0, rpt});
        settings_count++;
    endtask

    // Program a short or full-table sequence, start and tick it, disrupting short ones.
    task automatic play_scenario(input bit full_table);
        int    n;
        int    k;
        int    r;
        int    ticks;
        t_note nt;
        n     = full_table ? NOTE_DEPTH - 1 : $urandom_range(1, 6);
        ticks = 0;
        for (k = 0; k < n; k++) begin
            nt = random_note(2'($urandom_range(0, 1)));
            if (full_table) begin
                nt.length = LEN_W'($urandom_range(0, 1));
            end
            ticks += nt.length + 1;
            send_item(OP_WRITE, INDEX_W'(k), nt);
        end
        if (n < NOTE_DEPTH - 1) begin
            send_item(OP_WRITE, INDEX_W'(n), random_note(2'($urandom_range(2, 3))));
        end
        send_cmd(OP_START);
        ticks += $urandom_range(0, 4);
        if (!full_table && ticks > 220) begin
            ticks = 220;
        end
        for (k = 0; k < ticks; k++) begin
            r = full_table ? 99 : $urandom_range(99);
            if (r < 3) begin
                send_cmd(OP_STOP);
            end else if (r < 5) begin
                send_cmd(OP_START);
            end else if (r < 9) begin
                send_item(OP_WRITE, INDEX_W'($urandom_range(0, n)),
                          random_note(2'($urandom)));
            end else begin
                send_cmd(OP_TICK);
            end
        end
    endtask

    // Stopped block: ticks are ignored, and a start onto an end marker stays stopped.
    task automatic noise_scenario();
        int k;
        int n;
        n = $urandom_range(1, 3);
        send_cmd(OP_STOP);
        for (k = 0; k < n; k++) begin
            send_cmd(OP_TICK);
        end
        ignored_count += n;
        send_item(OP_WRITE, '0, random_note(2'($urandom_range(2, 3))));
        send_cmd(OP_START);
        send_cmd(OP_TICK);
    endtask

    initial begin
        int    k;
        int    seg;
        int    target;
        logic [7:0] mode;
        logic       rpt;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_config(8'd0, 1'b0);

        send_idle_pct = 22;
        recv_idle_pct = 51;

        // Fill the whole table so that no entry is ever read before it was written.
        for (k = 0; k < NOTE_DEPTH; k++) begin
            send_item(OP_WRITE, INDEX_W'(k), random_note(2'($urandom)));
        end

        // Directed: start onto an end marker, pitch extremes, kind code three, a write
        // during playback and a tick while stopped.
        send_item(OP_WRITE, 6'd0, make_note(18'd5, KIND_END, 8'd3));
        send_cmd(OP_START);
        send_cmd(OP_TICK);
        send_cmd(OP_STOP);
        send_item(OP_WRITE, 6'd0, make_note(18'd0, KIND_PAUSE, 8'd1));
        send_item(OP_WRITE, 6'd1, make_note(18'd7, KIND_TONE, 8'd0));
        send_item(OP_WRITE, 6'd2, make_note(18'd8, KIND_TONE, 8'd2));
        send_item(OP_WRITE, 6'd3, make_note(18'h3FFFF, KIND_TONE, 8'd1));
        send_item(OP_WRITE, 6'd4, make_note(18'h3FFFF, 2'd3, 8'd255));
        send_cmd(OP_START);
        for (k = 0; k < 9; k++) begin
            send_cmd(OP_TICK);
        end
        send_cmd(OP_START);
        send_item(OP_WRITE, 6'd1, make_note(18'd300, KIND_TONE, 8'd0));
        for (k = 0; k < 3; k++) begin
            send_cmd(OP_TICK);
        end
        send_cmd(OP_STOP);
        send_cmd(OP_TICK);

        for (seg = 0; seg < 6; seg++) begin
            case (seg)
                0:       begin mode = 8'd0;   rpt = 1'b0; end
                1:       begin mode = 8'd0;   rpt = 1'b1; end
                2:       begin mode = 8'd255; rpt = 1'b1; end
                3:       begin mode = 8'd1;   rpt = 1'b0; end
                4:       begin mode = 8'($urandom_range(2, 6)); rpt = 1'b1; end
                default: begin mode = 8'($urandom_range(2, 255)); rpt = 1'($urandom); end
            endcase
            set_config(mode, rpt);
            case (seg / 2)
                0:       begin send_idle_pct = 22; recv_idle_pct = 51; end
                1:       begin send_idle_pct = 51; recv_idle_pct = 22; end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase
            if (seg % 2 == 0) begin
                hold_requests++;
            end
            if (seg == 0) begin
                // A note of length 255 never advances, so the tick count wraps.
                send_item(OP_WRITE, 6'd0, make_note(18'd1000, KIND_TONE, 8'd255));
                send_item(OP_WRITE, 6'd1, make_note(18'd0, KIND_END, 8'd0));
                send_cmd(OP_START);
                for (k = 0; k < 258; k++) begin
                    send_cmd(OP_TICK);
                end
            end
            if (seg < 2) begin
                play_scenario(1'b1);
            end
            target = sent_count - ignored_count + SEGMENT_ITEMS;
            while (sent_count - ignored_count < target) begin
                if ($urandom_range(9) == 0) begin
                    noise_scenario();
                end else begin
                    play_scenario(1'b0);
                end
            end
        end

        wait_idle();
        $display("Sent %0d transactions (%0d ignored ticks) under %0d register settings.",
                 sent_count, ignored_count, settings_count);
        $display("Checked %0d results; %0d playbacks ran to an end marker.",
                 results_checked, playbacks_ended);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
